/* hw/rtl/kpsc_pkg.sv */
// ----------------------------------------------------------------------------
// kpsc_pkg
// Shared types, constants and lookup functions for the keypad stepper block.
// ----------------------------------------------------------------------------
package kpsc_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 4;
  localparam int SPT_W  = 13;
  localparam int BEAT_W = 18;

  localparam logic [SPT_W-1:0]         SPT_RESET  = 13'd4076;
  localparam logic [3:0]               COIL_IDLE  = 4'hF;
  localparam logic signed [BEAT_W-1:0] BEAT_LIMIT = 18'sd73719;

  // Key kinds: digits keep their value as code
  typedef enum logic [3:0] {
    KEY_D0    = 4'd0,
    KEY_D1    = 4'd1,
    KEY_D2    = 4'd2,
    KEY_D3    = 4'd3,
    KEY_D4    = 4'd4,
    KEY_D5    = 4'd5,
    KEY_D6    = 4'd6,
    KEY_D7    = 4'd7,
    KEY_D8    = 4'd8,
    KEY_D9    = 4'd9,
    KEY_UP    = 4'd10,
    KEY_LEFT  = 4'd11,
    KEY_DOWN  = 4'd12,
    KEY_RIGHT = 4'd13,
    KEY_ESC   = 4'd14,
    KEY_ENTER = 4'd15
  } key_kind_t;

  // Presses found on the scanned row this tick
  typedef struct packed {
    logic [1:0] row;
    logic [3:0] press;
  } press_t;

  // Motor state after the tick
  typedef struct packed {
    logic [2:0]               phase;
    logic [3:0]               coil;
    logic signed [BEAT_W-1:0] beats;
  } step_state_t;

  // Keypad layout, row-major
  function automatic key_kind_t key_kind(input logic [1:0] row, input logic [1:0] col);
    key_kind_t k;
    case ({row, col})
      4'd0:    k = KEY_D1;
      4'd1:    k = KEY_D2;
      4'd2:    k = KEY_D3;
      4'd3:    k = KEY_UP;
      4'd4:    k = KEY_D4;
      4'd5:    k = KEY_D5;
      4'd6:    k = KEY_D6;
      4'd7:    k = KEY_LEFT;
      4'd8:    k = KEY_D7;
      4'd9:    k = KEY_D8;
      4'd10:   k = KEY_D9;
      4'd11:   k = KEY_DOWN;
      4'd12:   k = KEY_D0;
      4'd13:   k = KEY_ESC;
      4'd14:   k = KEY_ENTER;
      4'd15:   k = KEY_RIGHT;
      default: k = KEY_ENTER;
    endcase
    return k;
  endfunction

  // Half-step coil sequence
  function automatic logic [3:0] phase_code(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd0:    c = 4'hE;
      3'd1:    c = 4'hC;
      3'd2:    c = 4'hD;
      3'd3:    c = 4'h9;
      3'd4:    c = 4'hB;
      3'd5:    c = 4'h3;
      3'd6:    c = 4'h7;
      3'd7:    c = 4'h6;
      default: c = COIL_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/kpsc_debounce.sv */
// ----------------------------------------------------------------------------
// kpsc_debounce
// Row scanner: per-key sample histories, debounced levels and press detect.
// ----------------------------------------------------------------------------
module kpsc_debounce #(
  parameter int SAMPLES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [3:0]      cols,
  output kpsc_pkg::press_t press,
  output logic [1:0]      scan_row
);
  import kpsc_pkg::*;

  logic [SAMPLES-1:0] hist [ROWS][COLS];
  logic [COLS-1:0]    level [ROWS];
  logic [SAMPLES-1:0] hist_next [COLS];
  logic [COLS-1:0]    level_next;

  // Shift in the new samples and settle the levels of the scanned row
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      hist_next[c]  = {hist[scan_row][c][SAMPLES-2:0], cols[c]};
      level_next[c] = level[scan_row][c];
      if (hist_next[c] == '0) begin
        level_next[c] = 1'b0;
      end else if (hist_next[c] == '1) begin
        level_next[c] = 1'b1;
      end
      press.press[c] = level[scan_row][c] & ~level_next[c];
    end
    press.row = scan_row;
  end

  // Store the row and step to the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          hist[r][c] <= '1;
        end
        level[r] <= '1;
      end
      scan_row <= 2'd0;
    end else if (advance) begin
      for (int c = 0; c < COLS; c++) begin
        hist[scan_row][c] <= hist_next[c];
      end
      level[scan_row] <= level_next;
      scan_row        <= scan_row + 2'd1;
    end
  end

endmodule

/* hw/rtl/kpsc_stepper.sv */
// ----------------------------------------------------------------------------
// kpsc_stepper
// Half-step motor sequencer with beat counter and key command decode.
// ----------------------------------------------------------------------------
module kpsc_stepper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  kpsc_pkg::press_t              press,
  input  logic [kpsc_pkg::SPT_W-1:0]    spt,
  output kpsc_pkg::step_state_t         state
);
  import kpsc_pkg::*;

  logic                     toggle;
  logic                     reverse;
  logic signed [BEAT_W-1:0] beats;
  logic [2:0]               phase;
  logic [3:0]               coil;

  logic signed [BEAT_W-1:0] beats_step;
  logic [2:0]               phase_step;
  logic [3:0]               coil_step;
  logic                     rev_run;
  logic                     load_any;
  logic                     load_rev;
  logic [3:0]               load_kind;
  key_kind_t                kind;
  logic [16:0]              prod;
  logic [BEAT_W-1:0]        quarter;
  logic signed [BEAT_W-1:0] load_val;
  logic signed [BEAT_W-1:0] beats_next;

  // Step the motor on every other tick, starting with the first
  always_comb begin
    beats_step = beats;
    phase_step = phase;
    coil_step  = coil;
    if (!toggle) begin
      if (beats > 0) begin
        phase_step = phase + 3'd1;
        beats_step = beats - 18'sd1;
        coil_step  = phase_code(phase_step);
      end else if (beats < 0) begin
        phase_step = phase - 3'd1;
        beats_step = beats + 18'sd1;
        coil_step  = phase_code(phase_step);
      end else begin
        coil_step = COIL_IDLE;
      end
    end
  end

  // Walk the row's presses in column order; the last beat load wins
  always_comb begin
    rev_run   = reverse;
    load_any  = 1'b0;
    load_rev  = reverse;
    load_kind = KEY_ESC;
    kind      = KEY_ENTER;
    for (int c = 0; c < 4; c++) begin
      kind = key_kind(press.row, 2'(c));
      if (press.press[c]) begin
        if (kind <= KEY_D9) begin
          load_any  = 1'b1;
          load_kind = kind;
          load_rev  = rev_run;
        end else begin
          case (kind)
            KEY_UP:   rev_run = 1'b0;
            KEY_DOWN: rev_run = 1'b1;
            KEY_LEFT, KEY_RIGHT, KEY_ESC: begin
              load_any  = 1'b1;
              load_kind = kind;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Beat value of the winning key
  assign prod    = {13'd0, load_kind} * {4'd0, spt};
  assign quarter = {7'd0, spt[SPT_W-1:2]};

  always_comb begin
    if (load_kind <= KEY_D9) begin
      load_val = load_rev ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    end else begin
      case (load_kind)
        KEY_LEFT:  load_val = $signed(quarter);
        KEY_RIGHT: load_val = -$signed(quarter);
        default:   load_val = '0;
      endcase
    end
    beats_next = load_any ? load_val : beats_step;
  end

  // Motor state registers double as the result
  always_ff @(posedge clk) begin
    if (rst) begin
      toggle  <= 1'b0;
      reverse <= 1'b0;
      beats   <= '0;
      phase   <= 3'd0;
      coil    <= COIL_IDLE;
    end else if (advance) begin
      toggle  <= ~toggle;
      reverse <= rev_run;
      beats   <= beats_next;
      phase   <= phase_step;
      coil    <= coil_step;
    end
  end

  assign state.phase = phase;
  assign state.coil  = coil;
  assign state.beats = beats;

endmodule

/* hw/rtl/keypad_stepper_controller.sv */
// ----------------------------------------------------------------------------
// keypad_stepper_controller
// Input transfer reaches result valid through the input register, then the
// state/result registers. One tick per cycle while the receiver does not stall.
// Reset (rst, synchronous): all keys released, row 0, forward, zero beats,
// coils idle (0xF), steps_per_turn 4076.
// ----------------------------------------------------------------------------
module keypad_stepper_controller #(
  parameter int DEBOUNCE_SAMPLES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] column_levels, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] row_drive, [7:4] coil_pattern, [25:8] beats_left
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // steps_per_turn
);
  import kpsc_pkg::*;

  logic              in_valid;
  logic [3:0]        in_cols;
  logic              advance;
  logic [SPT_W-1:0]  spt;
  logic [1:0]        scan_row;
  logic [3:0]        row_drive;
  press_t            press;
  step_state_t       motor;

  // Move the held tick into the state when the result slot is free
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cols <= s_tdata[3:0];
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      spt <= SPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      spt <= cfg_data;
    end
  end

  kpsc_debounce #(
    .SAMPLES (DEBOUNCE_SAMPLES)
  ) u_debounce (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cols     (in_cols),
    .press    (press),
    .scan_row (scan_row)
  );

  kpsc_stepper u_stepper (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .press   (press),
    .spt     (spt),
    .state   (motor)
  );

  // Pack the result
  assign row_drive = ~(4'b0001 << scan_row);
  assign m_tdata   = {6'd0, motor.beats, motor.coil, row_drive};

`ifndef ASSERT_OFF
  a_beats_range: assert property (@(posedge clk) disable iff (rst)
    (motor.beats <= BEAT_LIMIT) && (motor.beats >= -BEAT_LIMIT))
    else $error("beat count out of range");

  a_phase_moves_on_tick: assert property (@(posedge clk) disable iff (rst)
    (motor.phase != $past(motor.phase)) |-> $past(advance))
    else $error("phase changed without a tick");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance))
    else $error("result raised without a tick");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keypad_stepper_controller. Plays keypad presses
// (clean holds, bounce, raw noise) into the tick stream, predicts the row
// select, coil lines and remaining beats of every tick and checks each result
// transfer. Runs several steps_per_turn settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

  import kpsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // Keypad layout, row-major, key 0 in the lowest nibble
  localparam logic [63:0] KEY_MAP = {
    KEY_RIGHT, KEY_ENTER, KEY_ESC,  KEY_D0,
    KEY_DOWN,  KEY_D9,    KEY_D8,   KEY_D7,
    KEY_LEFT,  KEY_D6,    KEY_D5,   KEY_D4,
    KEY_UP,    KEY_D3,    KEY_D2,   KEY_D1
  };

  // Half-step coil sequence, phase 0 in the lowest nibble
  localparam logic [31:0] COIL_SEQ = {
    4'h6, 4'h7, 4'h3, 4'hB, 4'h9, 4'hD, 4'hC, 4'hE
  };

  // Result fields in tdata order, row_drive lowest
  typedef struct packed {
    logic signed [17:0] beats;
    logic [3:0]         coil;
    logic [3:0]         row_drive;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [3:0] column_levels, [7:4] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [3:0] row_drive, [7:4] coil_pattern, [25:8] beats_left
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = 13'd0;  // steps_per_turn

  // Stimulus and expectations
  logic [3:0]   column_queue [$];
  tick_result_t expected_ticks [$];
  int           src_idle_pct = 0;
  int           dst_stall_pct = 0;
  int           gen_row = 0;
  int           gen_count = 0;

  // Counters
  int mismatches = 0;
  int ticks_checked = 0;
  int key_actions = 0;
  int coil_steps = 0;
  int spt_settings = 1;
  int cycle_count = 0;

  // Predictor state
  logic [3:0]  col_history [16];
  logic        debounced [16];
  logic        last_debounced [16];
  logic [1:0]  row_sel = 2'd0;
  logic        reverse_dir = 1'b0;
  int          beats_pending = 0;
  logic [2:0]  phase_pos = 3'd0;
  logic        step_phase = 1'b0;
  logic [3:0]  coil_out = COIL_IDLE;
  logic [12:0] turn_beats = SPT_RESET;

  keypad_stepper_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      col_history[i]    = 4'hF;
      debounced[i]      = 1'b1;
      last_debounced[i] = 1'b1;
    end
  end

  // Advance the keypad/motor state by one tick and return its result
  function automatic tick_result_t predict_tick(input logic [3:0] cols);
    tick_result_t res;
    logic [3:0]   idx;
    logic [3:0]   hist;
    key_kind_t    kind;
    int           n;
    for (int k = 0; k < 4; k++) begin
      idx  = {row_sel, k[1:0]};
      hist = {col_history[idx][2:0], cols[k]};
      col_history[idx] = hist;
      if (hist == 4'h0) begin
        debounced[idx] = 1'b0;
      end else if (hist == 4'hF) begin
        debounced[idx] = 1'b1;
      end
    end
    row_sel = row_sel + 2'd1;

    // Step the motor on every other tick
    step_phase = ~step_phase;
    if (step_phase) begin
      if (beats_pending > 0) begin
        phase_pos = phase_pos + 3'd1;
        beats_pending--;
        coil_out = COIL_SEQ[phase_pos*4 +: 4];
        coil_steps++;
      end else if (beats_pending < 0) begin
        phase_pos = phase_pos - 3'd1;
        beats_pending++;
        coil_out = COIL_SEQ[phase_pos*4 +: 4];
        coil_steps++;
      end else begin
        coil_out = COIL_IDLE;
      end
    end

    // Act on new presses in row-major order
    for (int k = 0; k < 16; k++) begin
      if (last_debounced[k] != debounced[k]) begin
        if (last_debounced[k]) begin
          kind = key_kind_t'(KEY_MAP[k*4 +: 4]);
          key_actions++;
          case (kind)
            KEY_UP:    reverse_dir = 1'b0;
            KEY_DOWN:  reverse_dir = 1'b1;
            KEY_LEFT:  beats_pending = (int'(turn_beats) * 90) / 360;
            KEY_RIGHT: beats_pending = -((int'(turn_beats) * 90) / 360);
            KEY_ESC:   beats_pending = 0;
            KEY_ENTER: ;
            default: begin
              n = int'(kind) * int'(turn_beats);
              beats_pending = reverse_dir ? -n : n;
            end
          endcase
        end
        last_debounced[k] = debounced[k];
      end
    end

    res.row_drive = ~(4'b0001 << row_sel);
    res.coil      = coil_out;
    res.beats     = beats_pending[17:0];
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // Tick driver: feed column samples from the queue, predict on transfer
  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_ticks.push_back(predict_tick(s_tdata[3:0]));
      end
      if (!s_tvalid || s_tready) begin
        if (column_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tdata  <= {4'b0000, column_queue.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin : monitor
    tick_result_t want;
    tick_result_t seen;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = tick_result_t'(m_tdata[25:0]);
        if (expected_ticks.size() == 0) begin
          flag_error($sformatf("result with no tick pending, tdata %h", m_tdata));
        end else begin
          want = expected_ticks.pop_front();
          if (seen.row_drive !== want.row_drive || seen.coil !== want.coil ||
              seen.beats !== want.beats) begin
            flag_error($sformatf(
              "tick %0d: row_drive exp %h got %h, coil exp %h got %h, beats exp %0d got %0d",
              ticks_checked, want.row_drive, seen.row_drive, want.coil, seen.coil,
              want.beats, seen.beats));
          end
        end
        ticks_checked++;
      end
      m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d ticks still expected",
               cycle_count, expected_ticks.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Queue one column sample for the row the block will be scanning then
  task automatic queue_tick(input logic [3:0] cols);
    column_queue.push_back(cols);
    gen_row = (gen_row + 1) % 4;
    gen_count++;
  endtask

  // Hold a set of keys down for a number of ticks, optionally bouncing
  task automatic hold_keys(input logic [15:0] pressed, input int ticks, input bit bouncy);
    logic [3:0] cols;
    for (int t = 0; t < ticks; t++) begin
      cols = ~pressed[gen_row*4 +: 4];
      if (bouncy && t < 3 && $urandom_range(99) < 30) begin
        cols[$urandom_range(3)] ^= 1'b1;
      end
      queue_tick(cols);
    end
  endtask

  // Wait until every queued tick has gone through and its result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (column_queue.size() != 0 || s_tvalid || expected_ticks.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_spt(input logic [12:0] value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    turn_beats = value;
    spt_settings++;
  endtask

  task automatic begin_phase(input logic [12:0] spt, input int src_pct, input int dst_pct);
    write_spt(spt);
    @(negedge clk);
    src_idle_pct  = src_pct;
    dst_stall_pct = dst_pct;
  endtask

  // Random keypad activity: mostly clean presses, some bounce, chords and noise
  task automatic play_keys(input int n_items);
    int          stop;
    logic [15:0] pressed;
    @(negedge clk);
    stop = gen_count + n_items;
    while (gen_count < stop) begin
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 8)) queue_tick(4'($urandom_range(15)));
        end
        1: hold_keys(16'h0000, $urandom_range(16, 20), 1'b0);
        2: begin
          pressed = 16'h0000;
          pressed[$urandom_range(15)] = 1'b1;
          pressed[$urandom_range(15)] = 1'b1;
          hold_keys(pressed, $urandom_range(16, 22), $urandom_range(2) == 0);
        end
        default: begin
          pressed = 16'h0000;
          pressed[$urandom_range(15)] = 1'b1;
          hold_keys(pressed, $urandom_range(16, 22), $urandom_range(2) == 0);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: every key at once at the reset setting, then all released
    @(negedge clk);
    hold_keys(16'hFFFF, 16, 1'b0);
    hold_keys(16'h0000, 8, 1'b0);

    // Smallest nonzero turn, back-to-back, with a full drain midway
    begin_phase(13'd1, 0, 0);
    play_keys(40);
    wait_drained();
    play_keys(40);

    // Largest turn, bursty sender
    begin_phase(13'h1FFF, 61, 0);
    hold_keys(16'h0800, 16, 1'b0);
    hold_keys(16'h0400, 16, 1'b0);
    play_keys(60);

    // Zero turn, stalling receiver
    begin_phase(13'd0, 0, 61);
    play_keys(50);

    // Short turns, light idling on both sides
    begin_phase(13'd3, 11, 11);
    play_keys(80);

    // Random turn size, no idling
    begin_phase(13'($urandom_range(2, 8190)), 0, 0);
    play_keys(50);

    wait_drained();
    if (expected_ticks.size() != 0) begin
      flag_error($sformatf("%0d ticks never produced a result", expected_ticks.size()));
    end

    $display("Checked %0d ticks over %0d steps_per_turn settings", ticks_checked,
             spt_settings);
    $display("Predicted %0d key actions and %0d coil steps, %0d mismatches", key_actions,
             coil_steps, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
